// ===== rtl/midi_track_merge_sequencer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// midi track merge sequencer assertion macros
// shared concurrent check forms used by the top level
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_MERGE_SEQUENCER_UNIT_DEFINES_SVH
`define MIDI_TRACK_MERGE_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MTMS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtms check failed");

// next-cycle implication, quiet during reset
`define MTMS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mtms check failed");

`endif

// ===== rtl/mtms_pkg.sv =====
// ----------------------------------------------------------------------------
// mtms_pkg
// types and constants shared by the track merge sequencer modules
// ----------------------------------------------------------------------------
package mtms_pkg;

	localparam int MAX_TRACK_SLOTS = 64;
	localparam int TRACK_W         = 6;
	localparam int HEAD_W          = 45;
	localparam int TICK_W          = 32;
	localparam int PROD_W          = 56;

	localparam logic [23:0] DEFAULT_BEAT_US = 24'd500000;
	localparam logic [15:0] DEFAULT_TPQ     = 16'd96;
	localparam logic [6:0]  MAX_TRACKS_7    = 7'd64;

	// input event kinds
	localparam logic [2:0] EV_NOTE_ON  = 3'd0;
	localparam logic [2:0] EV_NOTE_OFF = 3'd1;
	localparam logic [2:0] EV_PROGRAM  = 3'd2;
	localparam logic [2:0] EV_TEMPO    = 3'd3;
	localparam logic [2:0] EV_END      = 3'd4;

	// result kinds
	localparam logic [2:0] OUT_NOTE_ON  = 3'd0;
	localparam logic [2:0] OUT_NOTE_OFF = 3'd1;
	localparam logic [2:0] OUT_PROGRAM  = 3'd2;
	localparam logic [2:0] OUT_END      = 3'd3;
	localparam logic [2:0] OUT_FETCH    = 3'd4;

	// configuration register indexes
	localparam logic REG_TPQ    = 1'b0;
	localparam logic REG_TRACKS = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_CHECK,
		S_SCAN,
		S_MUL,
		S_DIV,
		S_TAIL
	} mtms_state_t;

	// head event fields
	typedef struct packed {
		logic [23:0] tempo;
		logic [6:0]  p2;
		logic [6:0]  p1;
		logic [3:0]  ch;
		logic [2:0]  kind;
	} mtms_head_t;

	// divider control
	typedef struct packed {
		logic        start;
		logic [15:0] divisor;
	} mtms_div_ctl_t;

endpackage

// ===== rtl/mtms_ram.sv =====
// ----------------------------------------------------------------------------
// mtms_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module mtms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ===== rtl/mtms_div.sv =====
// ----------------------------------------------------------------------------
// mtms_div
// restoring divider, one quotient bit per cycle over the product width
// ----------------------------------------------------------------------------
module mtms_div import mtms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  mtms_div_ctl_t       ctl,
	input  logic [PROD_W-1:0]   dividend,
	output logic                busy,
	output logic                done,
	output logic [31:0]         quotient
);

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [16:0]       rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [15:0]       div_q;
	logic              done_q;
	logic [16:0]       trial;
	logic              fits;

	// one trial subtraction per step
	always_comb begin
		trial = {rem_q[15:0], quo_q[PROD_W-1]};
		fits  = trial >= {1'b0, div_q};
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				cnt_q <= CNT_W'(PROD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= ctl.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[PROD_W-2:0], fits};
		end
	end

	assign busy     = cnt_q != '0;
	assign done     = done_q;
	assign quotient = quo_q[31:0];

endmodule

// ===== rtl/midi_track_merge_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// midi_track_merge_sequencer_unit
// merges up to 64 midi tracks into one timed event stream
// ----------------------------------------------------------------------------
// Usage: pulse start with a track head item while busy is low; the item is
// taken on that edge and busy rises until its work is over, except after an
// end record, when items are dropped and busy stays low. Results come on the
// result ports for one cycle each, marked by result_valid, and the receiver
// cannot stall them; last marks the final result of an item.
// Configuration writes use cfg_valid/cfg_ready with cfg_index selecting
// ticks_per_quarter (0) or track_count (1); cfg_ready is high when idle and
// start is low. Writing track_count restarts the merge at once.
// Per-track ticks and head events live in two 64-entry rams. An item that
// only loads a head passes through the load and check states. An item that
// completes a pick adds a scan through the tick ram, a multiply state and a
// divide (start, 56 bit steps, done); busy stays high throughout and the next
// item is taken only after busy falls. A note or program result comes in the
// last busy cycle, a fetch or end record in the cycle after.
// Reset restores ticks_per_quarter 96, one active track, a 500000 us beat
// and clears all loaded marks; tick entries read as zero until written.
// ----------------------------------------------------------------------------
`include "midi_track_merge_sequencer_unit_defines.svh"

module midi_track_merge_sequencer_unit import mtms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        mode,
	input  logic [5:0]  track,
	input  logic [27:0] delta_ticks,
	input  logic [2:0]  event_kind,
	input  logic [3:0]  channel,
	input  logic [6:0]  param_one,
	input  logic [6:0]  param_two,
	input  logic [23:0] tempo_us,
	output logic        result_valid,
	output logic [2:0]  out_kind,
	output logic [31:0] gap_us,
	output logic [3:0]  out_channel,
	output logic [6:0]  out_note,
	output logic [6:0]  out_velocity,
	output logic [5:0]  fetch_track,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	mtms_state_t st_q, st_n;

	logic [15:0] tpq_q;
	logic [MAX_TRACK_SLOTS-1:0] act_q, ld_q, tv_q;
	logic [23:0] beat_q;
	logic [31:0] prev_q, pend_q;
	logic        done_q;

	logic              in_mode_q;
	logic [5:0]        in_track_q;
	logic [27:0]       in_delta_q;
	mtms_head_t        in_head_q;

	logic [6:0]  cnt_q;
	logic [5:0]  idx_s1;
	logic        vld_s1;
	logic [31:0] best_q, best_n;
	logic [5:0]  sel_q, sel_n;
	logic [31:0] tick_gap;
	logic [PROD_W-1:0] prod_q;
	mtms_head_t  head_q;

	logic        tv_rd_q;
	logic        tick_we, head_we;
	logic [5:0]  tick_addr, head_addr;
	logic [31:0] tick_wdata, tick_rdata, tick_val;
	logic [HEAD_W-1:0] head_rdata;

	mtms_div_ctl_t div_ctl;
	logic        div_busy, div_done;
	logic [31:0] div_q;

	logic accept, cfg_fire, any_act, all_ld, elig, scan_hit;
	logic [6:0] n_clamp;

	// state rams
	mtms_ram #(.WIDTH(TICK_W), .DEPTH(MAX_TRACK_SLOTS)) u_tick_ram (
		.clk(clk), .we(tick_we), .addr(tick_addr), .wdata(tick_wdata), .rdata(tick_rdata)
	);

	mtms_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_TRACK_SLOTS)) u_head_ram (
		.clk(clk), .we(head_we), .addr(head_addr), .wdata(in_head_q), .rdata(head_rdata)
	);

	mtms_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl), .dividend(prod_q),
		.busy(div_busy), .done(div_done), .quotient(div_q)
	);

	// status terms
	always_comb begin
		accept    = start && !busy;
		cfg_fire  = cfg_valid && cfg_ready;
		n_clamp   = (cfg_data[6:0] > MAX_TRACKS_7) ? MAX_TRACKS_7 : cfg_data[6:0];
		any_act   = |act_q;
		all_ld    = &(~act_q | ld_q);
		elig      = act_q[in_track_q] && !ld_q[in_track_q];
		tick_val  = tv_rd_q ? tick_rdata : 32'd0;
		scan_hit  = vld_s1 && act_q[idx_s1] && (tick_val <= best_q);
		best_n    = scan_hit ? tick_val : best_q;
		sel_n     = scan_hit ? idx_s1 : sel_q;
		tick_gap  = best_q - prev_q;
	end

	// next state
	always_comb begin
		st_n = st_q;
		case (st_q)
			S_IDLE:  if (accept && !done_q) st_n = S_LOAD;
			S_LOAD:  st_n = S_CHECK;
			S_CHECK: st_n = (any_act && all_ld) ? S_SCAN : S_IDLE;
			S_SCAN:  if (cnt_q == MAX_TRACKS_7) st_n = S_MUL;
			S_MUL:   st_n = S_DIV;
			S_DIV:   if (div_done) st_n = S_TAIL;
			S_TAIL:  st_n = S_IDLE;
			default: st_n = S_IDLE;
		endcase
	end

	// ram and divider controls
	always_comb begin
		tick_we    = 1'b0;
		head_we    = 1'b0;
		tick_addr  = in_track_q;
		head_addr  = in_track_q;
		tick_wdata = tick_val + {4'd0, in_delta_q};
		div_ctl    = '{start: 1'b0, divisor: (tpq_q == '0) ? DEFAULT_TPQ : tpq_q};
		case (st_q)
			S_IDLE: tick_addr = track;
			S_LOAD: begin
				tick_we = elig && !in_mode_q;
				head_we = elig && !in_mode_q;
			end
			S_SCAN: begin
				tick_addr = cnt_q[5:0];
				head_addr = sel_n;
			end
			// product is registered by now, start once
			S_DIV:   div_ctl.start = !div_busy && !div_done;
			default: ;
		endcase
	end

	assign busy      = st_q != S_IDLE;
	assign cfg_ready = (st_q == S_IDLE) && !start;

	// control and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			tpq_q        <= DEFAULT_TPQ;
			act_q        <= MAX_TRACK_SLOTS'(1);
			ld_q         <= '0;
			tv_q         <= '0;
			beat_q       <= DEFAULT_BEAT_US;
			prev_q       <= '0;
			pend_q       <= '0;
			done_q       <= 1'b0;
			cnt_q        <= '0;
			vld_s1       <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			st_q         <= st_n;
			result_valid <= 1'b0;
			// configuration writes
			if (cfg_fire && cfg_index == REG_TPQ) begin
				tpq_q <= cfg_data;
			end else if (cfg_fire && cfg_index == REG_TRACKS) begin
				for (int t = 0; t < MAX_TRACK_SLOTS; t++) begin
					act_q[t] <= 7'(t) < n_clamp;
				end
				ld_q   <= '0;
				tv_q   <= '0;
				beat_q <= DEFAULT_BEAT_US;
				prev_q <= '0;
				pend_q <= '0;
				done_q <= 1'b0;
			end
			case (st_q)
				S_LOAD: begin
					if (elig && in_mode_q) begin
						act_q[in_track_q] <= 1'b0;
					end else if (elig) begin
						ld_q[in_track_q] <= 1'b1;
						tv_q[in_track_q] <= 1'b1;
					end
				end
				S_CHECK: begin
					cnt_q  <= '0;
					vld_s1 <= 1'b0;
					if (!any_act) begin
						result_valid <= 1'b1;
						done_q       <= 1'b1;
					end
				end
				S_SCAN: begin
					cnt_q  <= cnt_q + 1'b1;
					vld_s1 <= cnt_q != MAX_TRACKS_7;
				end
				S_MUL: begin
					prev_q       <= best_q;
					ld_q[sel_q]  <= 1'b0;
				end
				S_DIV: begin
					if (div_done) begin
						if (head_q.kind == EV_NOTE_ON || head_q.kind == EV_NOTE_OFF ||
							head_q.kind == EV_PROGRAM) begin
							pend_q       <= '0;
							result_valid <= 1'b1;
						end else begin
							pend_q <= pend_q + div_q;
							if (head_q.kind == EV_TEMPO) beat_q <= head_q.tempo;
							if (head_q.kind == EV_END) act_q[sel_q] <= 1'b0;
						end
					end
				end
				S_TAIL: begin
					if (act_q[sel_q]) begin
						result_valid <= 1'b1;
					end else if (!any_act) begin
						result_valid <= 1'b1;
						done_q       <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		tv_rd_q <= tv_q[tick_addr];
		if (accept) begin
			in_mode_q  <= mode;
			in_track_q <= track;
			in_delta_q <= delta_ticks;
			in_head_q  <= '{tempo: tempo_us, p2: param_two, p1: param_one,
				ch: channel, kind: event_kind};
		end
		case (st_q)
			S_CHECK: begin
				best_q       <= 32'hFFFF_FFFF;
				sel_q        <= '0;
				out_kind     <= OUT_END;
				gap_us       <= '0;
				out_channel  <= '0;
				out_note     <= '0;
				out_velocity <= '0;
				fetch_track  <= '0;
				last         <= 1'b1;
			end
			S_SCAN: begin
				best_q <= best_n;
				sel_q  <= sel_n;
				idx_s1 <= cnt_q[5:0];
			end
			S_MUL: begin
				head_q <= head_rdata;
				prod_q <= PROD_W'(tick_gap * beat_q);
			end
			S_DIV: begin
				// note, note off or program result
				out_kind     <= (head_q.kind == EV_NOTE_ON && head_q.p2 == '0) ?
					OUT_NOTE_OFF : head_q.kind;
				gap_us       <= pend_q + div_q;
				out_channel  <= head_q.ch;
				out_note     <= head_q.p1;
				out_velocity <= (head_q.kind == EV_NOTE_ON) ? head_q.p2 : 7'd0;
				fetch_track  <= '0;
				last         <= 1'b0;
			end
			S_TAIL: begin
				out_kind     <= act_q[sel_q] ? OUT_FETCH : OUT_END;
				gap_us       <= '0;
				out_channel  <= '0;
				out_note     <= '0;
				out_velocity <= '0;
				fetch_track  <= act_q[sel_q] ? sel_q : 6'd0;
				last         <= 1'b1;
			end
			default: ;
		endcase
	end

	// checks
	`MTMS_ASSERT_NOW(a_fetch_last, result_valid && out_kind == OUT_FETCH, last)
	`MTMS_ASSERT_NEXT(a_end_final, result_valid && out_kind == OUT_END && !cfg_fire, !result_valid)
	`MTMS_ASSERT_NOW(a_div_idle, st_q == S_IDLE, !div_busy)

endmodule

// ===== dv/mtms_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtms_checker
// predicts the merged midi event stream and compares every result transfer
// ----------------------------------------------------------------------------
// Watches the item, configuration and result channels of the track merge
// sequencer. Every accepted item runs through a cycle-free model of the
// merge, which queues the results it should cause. Each result transfer is
// checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module mtms_checker import mtms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        mode,
	input  logic [5:0]  track,
	input  logic [27:0] delta_ticks,
	input  logic [2:0]  event_kind,
	input  logic [3:0]  channel,
	input  logic [6:0]  param_one,
	input  logic [6:0]  param_two,
	input  logic [23:0] tempo_us,
	input  logic        result_valid,
	input  logic [2:0]  out_kind,
	input  logic [31:0] gap_us,
	input  logic [3:0]  out_channel,
	input  logic [6:0]  out_note,
	input  logic [6:0]  out_velocity,
	input  logic [5:0]  fetch_track,
	input  logic        last,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] delay;
		logic [3:0]  ch;
		logic [6:0]  note;
		logic [6:0]  vel;
		logic [5:0]  ft;
		logic        fin;
	} song_event_t;

	song_event_t expected_events[$];

	// merge state
	logic [15:0] tpq;
	logic [6:0]  track_limit;
	logic [31:0] head_tick [MAX_TRACK_SLOTS];
	logic        active    [MAX_TRACK_SLOTS];
	logic        loaded    [MAX_TRACK_SLOTS];
	mtms_head_t  head      [MAX_TRACK_SLOTS];
	logic [23:0] beat_us;
	logic [31:0] prev_tick;
	logic [31:0] accum_us;
	logic        song_ended;

	task automatic restart_merge();
		for (int t = 0; t < MAX_TRACK_SLOTS; t++) begin
			head_tick[t] = '0;
			loaded[t]    = 1'b0;
			active[t]    = (t < track_limit);
		end
		beat_us    = DEFAULT_BEAT_US;
		prev_tick  = '0;
		accum_us   = '0;
		song_ended = 1'b0;
	endtask

	function automatic song_event_t make_event(logic [2:0] k, logic [31:0] d, logic [3:0] c,
			logic [6:0] n, logic [6:0] v, logic [5:0] f);
		song_event_t e;
		e.kind  = k;
		e.delay = d;
		e.ch    = c;
		e.note  = n;
		e.vel   = v;
		e.ft    = f;
		e.fin   = 1'b0;
		return e;
	endfunction

	// one item through the merge: load, pick, time, emit
	task automatic merge_item();
		song_event_t recs [2];
		int          cnt;
		int          sel;
		logic        any_act;
		logic        all_ld;
		logic [31:0] best;
		logic [31:0] at;
		logic [31:0] tick_gap;
		logic [15:0] div;
		logic [63:0] prod;
		mtms_head_t  h;
		logic [6:0]  vel;
		logic [2:0]  ok;
		cnt = 0;
		sel = 0;
		if (song_ended)
			return;
		if (active[track] && !loaded[track]) begin
			if (mode) begin
				active[track] = 1'b0;
			end else begin
				head_tick[track] = head_tick[track] + {4'd0, delta_ticks};
				head[track]      = '{tempo: tempo_us, p2: param_two, p1: param_one,
					ch: channel, kind: event_kind};
				loaded[track]    = 1'b1;
			end
		end
		any_act = 1'b0;
		all_ld  = 1'b1;
		for (int t = 0; t < MAX_TRACK_SLOTS; t++) begin
			if (active[t]) begin
				any_act = 1'b1;
				if (!loaded[t])
					all_ld = 1'b0;
			end
		end
		if (any_act && all_ld) begin
			// least tick wins, ties to the higher index
			best = '1;
			for (int t = 0; t < MAX_TRACK_SLOTS; t++) begin
				if (active[t] && head_tick[t] <= best) begin
					best = head_tick[t];
					sel  = t;
				end
			end
			at        = head_tick[sel];
			div       = (tpq != 0) ? tpq : DEFAULT_TPQ;
			tick_gap  = at - prev_tick;
			prod      = 64'(tick_gap) * 64'(beat_us);
			accum_us  = accum_us + 32'(prod / 64'(div));
			prev_tick = at;
			h         = head[sel];
			loaded[sel] = 1'b0;
			case (h.kind)
				EV_NOTE_ON, EV_NOTE_OFF, EV_PROGRAM: begin
					ok  = h.kind;
					vel = '0;
					if (h.kind == EV_NOTE_ON) begin
						if (h.p2 != 0)
							vel = h.p2;
						else
							ok = OUT_NOTE_OFF;
					end
					recs[cnt] = make_event(ok, accum_us, h.ch, h.p1, vel, '0);
					cnt++;
					accum_us = '0;
				end
				EV_TEMPO: beat_us = h.tempo;
				EV_END:   active[sel] = 1'b0;
				default:  ;
			endcase
			if (active[sel]) begin
				recs[cnt] = make_event(OUT_FETCH, '0, '0, '0, '0, 6'(sel));
				cnt++;
			end else begin
				any_act = 1'b0;
				for (int t = 0; t < MAX_TRACK_SLOTS; t++)
					if (active[t])
						any_act = 1'b1;
			end
		end
		if (!any_act) begin
			recs[cnt] = make_event(OUT_END, '0, '0, '0, '0, '0);
			cnt++;
			song_ended = 1'b1;
		end
		for (int i = 0; i < cnt; i++) begin
			recs[i].fin = (i == cnt - 1);
			expected_events.push_back(recs[i]);
		end
	endtask

	task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count  = 0;
			tpq         = DEFAULT_TPQ;
			track_limit = 7'd1;
			restart_merge();
			expected_events.delete();
		end else begin
			// result transfer against the oldest expectation
			if (result_valid) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result transfer, kind %0d", out_kind);
					fail_count++;
				end else begin
					song_event_t e;
					e = expected_events.pop_front();
					check_field("out_kind", e.kind, out_kind);
					check_field("gap_us", e.delay, gap_us);
					check_field("out_channel", e.ch, out_channel);
					check_field("out_note", e.note, out_note);
					check_field("out_velocity", e.vel, out_velocity);
					check_field("fetch_track", e.ft, fetch_track);
					check_field("last", e.fin, last);
				end
			end
			// register write transfer
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TPQ) begin
					tpq = cfg_data;
				end else begin
					track_limit = (cfg_data[6:0] > MAX_TRACKS_7) ? MAX_TRACKS_7 : cfg_data[6:0];
					restart_merge();
				end
			end
			// item transfer
			if (start && !busy)
				merge_item();
		end
		pending = expected_events.size();
	end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the midi track merge sequencer
// ----------------------------------------------------------------------------
// Plays a series of songs, each under its own time division and track count,
// feeding every track head the block asks for. A short directed song covers
// the corner events, then random songs follow with noise items mixed in.
// Checking is done by mtms_checker.
// ----------------------------------------------------------------------------
module tb import mtms_pkg::*; ();

	localparam logic [2:0] EV_OTHER = 3'd5;
	localparam logic [2:0] EV_ODD6  = 3'd6;
	localparam logic [2:0] EV_ODD7  = 3'd7;
	localparam logic MODE_EVENT  = 1'b0;
	localparam logic MODE_RETIRE = 1'b1;
	localparam int ITEM_TARGET  = 1200;
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 2000000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        mode;
	logic [5:0]  track;
	logic [27:0] delta_ticks;
	logic [2:0]  event_kind;
	logic [3:0]  channel;
	logic [6:0]  param_one;
	logic [6:0]  param_two;
	logic [23:0] tempo_us;
	logic        result_valid;
	logic [2:0]  out_kind;
	logic [31:0] gap_us;
	logic [3:0]  out_channel;
	logic [6:0]  out_note;
	logic [6:0]  out_velocity;
	logic [5:0]  fetch_track;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [15:0] cfg_data;
	int          fail_count;
	int          pending;

	int   fetch_queue[$];
	logic song_over;
	int   fed_items;
	int   directed_idx;
	int   cycles;

	midi_track_merge_sequencer_unit u_dut (.*);

	mtms_checker u_checker (.*);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// fetch requests tell which track to feed next
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (out_kind == OUT_FETCH)
				fetch_queue.push_back(fetch_track);
			if (out_kind == OUT_END)
				song_over = 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_item(logic m, logic [5:0] tr, logic [27:0] dl, logic [2:0] k,
			logic [3:0] ch, logic [6:0] p1, logic [6:0] p2, logic [23:0] tp);
		@(negedge clk);
		while (busy)
			@(negedge clk);
		start       <= 1'b1;
		mode        <= m;
		track       <= tr;
		delta_ticks <= dl;
		event_kind  <= k;
		channel     <= ch;
		param_one   <= p1;
		param_two   <= p2;
		tempo_us    <= tp;
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		while (pending != 0 || busy)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_gap();
		if ((fed_items < 400 || fed_items >= 600) && $urandom_range(99) < 15)
			repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// random item for any track; drop it from the fetch list if it lands there
	task automatic send_noise();
		logic [5:0] tr;
		tr = 6'($urandom);
		for (int i = 0; i < fetch_queue.size(); i++)
			if (fetch_queue[i] == tr) begin
				fetch_queue.delete(i);
				break;
			end
		send_item(1'($urandom), tr, 28'($urandom), 3'($urandom), 4'($urandom),
			7'($urandom), 7'($urandom), 24'($urandom));
	endtask

	// next head event for a track; corner events first, then random
	task automatic feed_track(int tr, logic force_end);
		logic        m;
		logic [27:0] dl;
		logic [2:0]  k;
		logic [3:0]  ch;
		logic [6:0]  p1;
		logic [6:0]  p2;
		logic [23:0] tp;
		int          r;
		m  = MODE_EVENT;
		ch = 4'($urandom);
		p1 = 7'($urandom);
		p2 = 7'($urandom_range(1, 127));
		tp = 24'($urandom_range(100000, 1000000));
		r  = $urandom_range(99);
		if (r < 60)      dl = 28'($urandom_range(0, 200));
		else if (r < 85) dl = 28'($urandom_range(0, 5000));
		else if (r < 95) dl = '0;
		else             dl = 28'($urandom);
		r = $urandom_range(99);
		if (r < 40)      k = EV_NOTE_ON;
		else if (r < 60) k = EV_NOTE_OFF;
		else if (r < 72) k = EV_PROGRAM;
		else if (r < 80) k = EV_TEMPO;
		else if (r < 86) k = EV_END;
		else if (r < 92) k = EV_OTHER;
		else             k = r[0] ? EV_ODD6 : EV_ODD7;
		if (k == EV_NOTE_ON && $urandom_range(9) == 0)
			p2 = '0;
		if (k == EV_TEMPO && r[1])
			tp = 24'($urandom);
		if ($urandom_range(99) < 3)
			m = MODE_RETIRE;
		if (force_end) begin
			m = r[0] ? MODE_RETIRE : MODE_EVENT;
			k = EV_END;
		end
		if (directed_idx < 14) begin
			case (directed_idx)
				0:  begin k = EV_NOTE_ON; ch = '0; p1 = '0; p2 = '0; dl = '0; end
				1:  begin k = EV_NOTE_ON; ch = 4'hF; p1 = 7'h7F; p2 = 7'h7F; dl = '0; end
				2:  begin k = EV_NOTE_OFF; dl = '0; end
				3:  begin k = EV_PROGRAM; p1 = 7'h7F; end
				4:  begin k = EV_TEMPO; tp = '0; end
				5:  begin k = EV_NOTE_ON; dl = 28'd500; end
				6:  begin k = EV_TEMPO; tp = '1; end
				7:  begin k = EV_OTHER; end
				8:  begin k = EV_ODD6; end
				9:  begin k = EV_ODD7; end
				10: begin k = EV_NOTE_ON; dl = '1; end
				11: begin k = EV_PROGRAM; dl = '1; p1 = '0; end
				12: begin k = EV_END; end
				default: m = MODE_RETIRE;
			endcase
			directed_idx++;
		end
		send_item(m, 6'(tr), dl, k, ch, p1, p2, tp);
	endtask

	initial begin
		int phase;
		int limit_n;
		int tracks_n;
		int song_items;
		int budget;
		int idx;
		logic [15:0] tpq_val;
		logic [15:0] cnt_val;
		cycles       = 0;
		arst_n       = 1'b0;
		start        = 1'b0;
		mode         = MODE_EVENT;
		track        = '0;
		delta_ticks  = '0;
		event_kind   = EV_NOTE_ON;
		channel      = '0;
		param_one    = '0;
		param_two    = '0;
		tempo_us     = '0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_TPQ;
		cfg_data     = '0;
		song_over    = 1'b0;
		fed_items    = 0;
		directed_idx = 0;
		phase        = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (fed_items < ITEM_TARGET) begin
			// settings for this song, extremes first
			case (phase)
				0:       begin tpq_val = DEFAULT_TPQ; cnt_val = 16'd3; end
				1:       begin tpq_val = 16'd0; cnt_val = 16'd64; end
				2:       begin tpq_val = 16'hFFFF; cnt_val = 16'd0; end
				3:       begin tpq_val = 16'd1; cnt_val = 16'h7F; end
				4:       begin tpq_val = 16'($urandom); cnt_val = 16'd1; end
				default: begin
					tpq_val = ($urandom_range(3) == 0) ? 16'($urandom)
						: 16'($urandom_range(24, 960));
					if ($urandom_range(9) < 7)
						cnt_val = 16'($urandom_range(1, 6));
					else
						cnt_val = 16'($urandom);
				end
			endcase
			phase++;
			wait_drained();
			write_reg(REG_TPQ, tpq_val);
			write_reg(REG_TRACKS, cnt_val);
			limit_n  = cnt_val[6:0];
			tracks_n = (limit_n > MAX_TRACK_SLOTS) ? MAX_TRACK_SLOTS : limit_n;
			song_over = 1'b0;
			fetch_queue.delete();
			for (int t = 0; t < tracks_n; t++)
				fetch_queue.push_back(t);
			song_items = 0;
			budget     = 3 * tracks_n + 30;
			if (tracks_n == 0)
				send_noise();

			while (!song_over) begin
				if (fetch_queue.size() == 0) begin
					// heads all loaded but nothing picked yet: any item triggers the pick
					@(negedge clk);
					if (!busy && pending == 0 && fetch_queue.size() == 0 && !song_over)
						send_noise();
				end else begin
					random_gap();
					if ($urandom_range(99) < 8)
						send_noise();
					if (fetch_queue.size() != 0) begin
						idx = $urandom_range(fetch_queue.size() - 1);
						feed_track(fetch_queue[idx], song_items >= budget);
						fetch_queue.delete(idx);
						fed_items++;
						song_items++;
					end
				end
			end
			// items after the end record are dropped
			if (phase % 3 == 0) begin
				wait_drained();
				send_noise();
				send_noise();
			end
		end

		wait_drained();
		if (fail_count == 0 && pending == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
